>>> src/polled_serial_frame_receiver_top_defines.svh
// ----------------------------------------------------------------------------
// polled serial frame receiver assertion macros
// shared property forms for the port checker, clocked on aclk and
// disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef POLLED_SERIAL_FRAME_RECEIVER_TOP_DEFINES_SVH
`define POLLED_SERIAL_FRAME_RECEIVER_TOP_DEFINES_SVH

// same-cycle implication
`define PSFR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PSFR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/psfr_pkg.sv
// ----------------------------------------------------------------------------
// psfr_pkg
// types and constants shared by the polled serial frame receiver
// ----------------------------------------------------------------------------
`default_nettype none

package psfr_pkg;

    localparam int LEN_W     = 16;
    localparam int ELAPSED_W = 19;
    localparam int INTV_W    = 18;

    localparam logic [7:0]           MARK_FIRST   = 8'h4E;
    localparam logic [7:0]           MARK_SECOND  = 8'h57;
    localparam logic [9:0]           MS_PER_S     = 10'd1000;
    localparam logic [8:0]           TIMEOUT_MARGIN_MS = 9'd250;
    localparam logic [7:0]           POLL_RESET_S = 8'd5;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX  = '1;
    localparam logic [LEN_W-1:0]     LEN_BIAS     = 16'd2;

    localparam logic [INTV_W-1:0]    INTERVAL_RESET_MS = INTV_W'(5 * 1000);
    localparam logic [ELAPSED_W-1:0] LIMIT_RESET_MS    = ELAPSED_W'(2 * 5 * 1000 + 250);

    typedef enum logic [5:0] {
        PS_IDLE       = 6'b000001,
        PS_WAIT_START = 6'b000010,
        PS_GOT_4E     = 6'b000100,
        PS_GOT_57     = 6'b001000,
        PS_GOT_MSB    = 6'b010000,
        PS_BODY       = 6'b100000
    } parse_state_t;

    typedef enum logic [2:0] {
        STATUS_NONE         = 3'd0,
        STATUS_BUSY         = 3'd1,
        STATUS_WAIT_INTV    = 3'd2,
        STATUS_TX_NOT_READY = 3'd3,
        STATUS_REQUEST      = 3'd4,
        STATUS_TIMEOUT      = 3'd5,
        STATUS_FRAME_DONE   = 3'd6
    } status_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
        logic       tx_ready;
    } item_t;

    typedef struct packed {
        parse_state_t         state;
        logic [LEN_W-1:0]     remaining;
        logic [ELAPSED_W-1:0] elapsed;
    } ctx_t;

    typedef struct packed {
        status_t    status;
        logic       send_request;
        logic [7:0] frame_byte;
        logic       byte_kept;
        logic       frame_end;
        logic       frame_drop;
    } result_t;

endpackage

`default_nettype wire

>>> src/psfr_step.sv
// ----------------------------------------------------------------------------
// psfr_step
// one-item update of the frame parser and the poll/timeout timer
// ----------------------------------------------------------------------------
`default_nettype none

module psfr_step (
    input  psfr_pkg::item_t                       item,
    input  psfr_pkg::ctx_t                        ctx,
    input  logic [psfr_pkg::INTV_W-1:0]           interval_ms,
    input  logic [psfr_pkg::ELAPSED_W-1:0]        limit_ms,
    output psfr_pkg::ctx_t                        ctx_next,
    output psfr_pkg::result_t                     result
);
    import psfr_pkg::*;

    logic [ELAPSED_W-1:0] elapsed_inc;
    logic [LEN_W-1:0]     body_left;
    logic                 drop;

    assign elapsed_inc = (ctx.elapsed == ELAPSED_MAX) ? ctx.elapsed
                                                      : ctx.elapsed + 1'b1;
    assign body_left   = ctx.remaining - 1'b1;

    always_comb begin
        ctx_next = ctx;
        result   = '0;
        result.status = STATUS_NONE;
        drop     = 1'b0;

        if (!item.mode) begin
            result.frame_byte = item.rx_byte;
            case (ctx.state)
                PS_IDLE, PS_WAIT_START: begin
                    if (item.rx_byte == MARK_FIRST) begin
                        ctx_next.state   = PS_GOT_4E;
                        result.byte_kept = 1'b1;
                    end else begin
                        drop = 1'b1;
                    end
                end
                PS_GOT_4E: begin
                    if (item.rx_byte == MARK_SECOND) begin
                        ctx_next.state   = PS_GOT_57;
                        result.byte_kept = 1'b1;
                    end else begin
                        drop = 1'b1;
                    end
                end
                PS_GOT_57: begin
                    ctx_next.remaining = {item.rx_byte, 8'h00};
                    ctx_next.state     = PS_GOT_MSB;
                    result.byte_kept   = 1'b1;
                end
                PS_GOT_MSB: begin
                    // length covers the two trailing bytes too, wraps in 16 bits
                    ctx_next.remaining = (ctx.remaining | {8'h00, item.rx_byte}) - LEN_BIAS;
                    ctx_next.state     = PS_BODY;
                    result.byte_kept   = 1'b1;
                end
                PS_BODY: begin
                    ctx_next.remaining = body_left;
                    result.byte_kept   = 1'b1;
                    if (body_left == '0) begin
                        result.frame_end = 1'b1;
                        result.status    = STATUS_FRAME_DONE;
                        ctx_next.state   = PS_IDLE;
                    end
                end
                default: begin
                    drop = 1'b1;
                end
            endcase
            if (drop) begin
                ctx_next.state = PS_IDLE;
            end
            result.frame_drop = drop;
        end else begin
            ctx_next.elapsed = elapsed_inc;
            if (ctx.state != PS_IDLE) begin
                result.status = STATUS_BUSY;
            end else if (elapsed_inc < {1'b0, interval_ms}) begin
                result.status = STATUS_WAIT_INTV;
            end else if (!item.tx_ready) begin
                result.status = STATUS_TX_NOT_READY;
            end else begin
                result.status       = STATUS_REQUEST;
                result.send_request = 1'b1;
                ctx_next.elapsed    = '0;
                ctx_next.state      = PS_WAIT_START;
            end
            // timeout overrides whatever the poll logic decided
            if (ctx_next.elapsed > limit_ms) begin
                result.frame_drop   = (ctx_next.state != PS_IDLE);
                ctx_next.state      = PS_IDLE;
                result.status       = STATUS_TIMEOUT;
                result.send_request = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/polled_serial_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// polled_serial_frame_receiver_top
// path: an s_ item is registered in the input reg, then its result in the result reg,
// which drives the m_ channel; each item is one pass of the psfr_step logic
// throughput: one item per cycle unless a low m_tready stalls the result reg
// reset: aresetn sync active low; clears parser state, length and elapsed
// counters and both valid flags; poll interval returns to 5 s
// ----------------------------------------------------------------------------
`default_nettype none

module polled_serial_frame_receiver_top (
    input  logic        aclk,
    input  logic        aresetn,
    // config: poll_interval_s
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] rx_byte, [8] tx_ready, [15:9] zero
    input  logic        s_tuser,   // [0] mode
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] send_request, [8:1] frame_byte,
                                   // [9] byte_kept, [10] frame_drop, [15:11] zero
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast    // frame_end
);
    import psfr_pkg::*;

    logic                 in_valid_reg, in_valid_next;
    item_t                item_reg;
    logic                 out_valid_reg, out_valid_next;
    result_t              result_reg;
    ctx_t                 ctx_reg;
    ctx_t                 ctx_next;
    result_t              result_next;
    logic [INTV_W-1:0]    interval_ms_reg, interval_ms_next;
    logic [ELAPSED_W-1:0] limit_ms_reg, limit_ms_next;
    logic                 in_xfer;
    logic                 advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_xfer  = s_tvalid && s_tready;

    assign in_valid_next  = in_xfer || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    // interval and timeout limit are worked out once per config write
    assign interval_ms_next = INTV_W'(cfg_wdata) * INTV_W'(MS_PER_S);
    assign limit_ms_next    = {interval_ms_next, 1'b0} + ELAPSED_W'(TIMEOUT_MARGIN_MS);

    psfr_step u_step (
        .item        (item_reg),
        .ctx         (ctx_reg),
        .interval_ms (interval_ms_reg),
        .limit_ms    (limit_ms_reg),
        .ctx_next    (ctx_next),
        .result      (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            ctx_reg.state   <= PS_IDLE;
            ctx_reg.remaining <= '0;
            ctx_reg.elapsed <= '0;
            interval_ms_reg <= INTERVAL_RESET_MS;
            limit_ms_reg    <= LIMIT_RESET_MS;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                ctx_reg <= ctx_next;
            end
            if (cfg_we) begin
                interval_ms_reg <= interval_ms_next;
                limit_ms_reg    <= limit_ms_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            item_reg.mode     <= s_tuser;
            item_reg.rx_byte  <= s_tdata[7:0];
            item_reg.tx_ready <= s_tdata[8];
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = result_reg.status;
    assign m_tlast  = result_reg.frame_end;
    assign m_tdata  = {5'b0, result_reg.frame_drop, result_reg.byte_kept,
                       result_reg.frame_byte, result_reg.send_request};

endmodule

`default_nettype wire

>>> src/psfr_checker.sv
// ----------------------------------------------------------------------------
// psfr_checker
// port-level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "polled_serial_frame_receiver_top_defines.svh"

module psfr_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [2:0]  m_tuser,
    input wire logic        m_tlast
);
    import psfr_pkg::*;

    // stalled result transfer holds
    `PSFR_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

    // a frame end always carries the frame-completed status and a kept byte
    `PSFR_ASSERT_IMP(a_end_status, m_tvalid && m_tlast, m_tuser == STATUS_FRAME_DONE && m_tdata[9], "frame end without completed status")

    // a request only comes with the request-sent status and no byte fields
    `PSFR_ASSERT_IMP(a_req_status, m_tvalid && m_tdata[0], m_tuser == STATUS_REQUEST && !m_tdata[9] && !m_tlast, "request with wrong status")

    // a kept byte is never dropped in the same result
    `PSFR_ASSERT_IMP(a_kept_drop, m_tvalid && m_tdata[9], !m_tdata[10], "byte kept and dropped")

endmodule

bind polled_serial_frame_receiver_top psfr_checker u_psfr_checker (.*);

`default_nettype wire
